// ----- src/tfp_pkg.sv -----
`default_nettype none
package tfp_pkg;

	localparam int DefValueWidth = 32;
	localparam int OutWidth = 32;

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_B256    = 3'd1;
	localparam logic [2:0] PH_LEAD    = 3'd2;
	localparam logic [2:0] PH_DIGITS  = 3'd3;
	localparam logic [2:0] PH_STOPPED = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	typedef struct packed {
		logic [2:0] phase;
		logic       neg;
	} tfp_ctl_t;

endpackage
`default_nettype wire

// ----- src/tfp_byte_if.sv -----
`default_nettype none
interface tfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] field_byte;
	logic       field_last;

	modport source (output valid, output field_byte, output field_last, input ready);
	modport sink (input valid, input field_byte, input field_last, output ready);
endinterface
`default_nettype wire

// ----- src/tfp_value_if.sv -----
`default_nettype none
interface tfp_value_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] field_value;

	modport source (output valid, output field_value, input ready);
	modport sink (input valid, input field_value, output ready);
endinterface
`default_nettype wire

// ----- src/tfp_parse_step.sv -----
`default_nettype none
module tfp_parse_step
	import tfp_pkg::*;
#(
	parameter int VALUE_WIDTH = DefValueWidth
) (
	input  wire tfp_ctl_t                  ctl,
	input  wire logic signed [VALUE_WIDTH-1:0] acc,
	input  wire logic [7:0]                field_byte,
	input  wire logic                      field_last,
	output tfp_ctl_t                       ctl_nxt,
	output logic signed [VALUE_WIDTH-1:0]  acc_nxt,
	output logic signed [OutWidth-1:0]     value
);

	localparam int W = VALUE_WIDTH;
	localparam int XW = (W > OutWidth) ? W : OutWidth;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] B_HI = VMAX >>> 8;
	localparam logic signed [W-1:0] B_LO = VMIN >>> 8;
	localparam logic signed [W-1:0] OCT_LIM = VMAX >>> 3;
	localparam logic signed [W-1:0] OCT_LAST = VMAX & W'(7);

	logic [2:0]             ph;
	logic                   n;
	logic signed [W-1:0]    a;
	logic signed [W-1:0]    d;
	logic                   is_digit;
	logic signed [W-1:0]    v;
	logic signed [XW-1:0]   v_x;

	always_comb begin
		ph = ctl.phase;
		n = ctl.neg;
		a = acc;
		d = $signed(W'(field_byte[2:0]));
		is_digit = (field_byte >= CH_ZERO) && (field_byte <= CH_SEVEN);

		case (ctl.phase)
			PH_FIRST: begin
				if (field_byte[7]) begin
					a = W'($signed(field_byte[6:0]));
					ph = PH_B256;
				end else begin
					ph = PH_LEAD;
				end
			end
			PH_B256: begin
				if (a > B_HI) begin
					a = VMAX;
					ph = PH_STOPPED;
				end else if (a < B_LO) begin
					a = VMIN;
					ph = PH_STOPPED;
				end else begin
					a = $signed({a[W-9:0], field_byte});
				end
			end
			default: ;
		endcase

		// an octal field's first byte falls through into the lead-in handling
		if (ph == PH_LEAD) begin
			if (field_byte == CH_SPACE || field_byte == CH_TAB) begin
				ph = PH_LEAD;
			end else if (field_byte == CH_MINUS && !n) begin
				n = 1'b1;
				ph = PH_DIGITS;
			end else if (!is_digit) begin
				ph = PH_STOPPED;
			end else if (a > OCT_LIM || (a == OCT_LIM && d > OCT_LAST)) begin
				a = VMAX;
				ph = PH_STOPPED;
			end else begin
				a = $signed({a[W-4:0], 3'b000}) + d;
				ph = PH_DIGITS;
			end
		end else if (ph == PH_DIGITS) begin
			if (!is_digit) begin
				ph = PH_STOPPED;
			end else if (a > OCT_LIM || (a == OCT_LIM && d > OCT_LAST)) begin
				a = VMAX;
				ph = PH_STOPPED;
			end else begin
				a = $signed({a[W-4:0], 3'b000}) + d;
			end
		end

		v = n ? -a : a;
		v_x = XW'(v);
		value = $signed(v_x[OutWidth-1:0]);

		if (field_last) begin
			ctl_nxt.phase = PH_FIRST;
			ctl_nxt.neg = 1'b0;
			acc_nxt = '0;
		end else begin
			ctl_nxt.phase = ph;
			ctl_nxt.neg = n;
			acc_nxt = a;
		end
	end

endmodule
`default_nettype wire

// ----- src/tfp_result_reg.sv -----
`default_nettype none
module tfp_result_reg
	import tfp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic signed [OutWidth-1:0] value,
	output logic                           free,
	tfp_value_if.source                    value_ch
);

	logic                      valid_q;
	logic signed [OutWidth-1:0] value_q;

	assign free = !valid_q || value_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			value_q <= value;
		end
	end

	assign value_ch.valid = valid_q;
	assign value_ch.field_value = value_q;

endmodule
`default_nettype wire

// ----- src/tar_numeric_field_parser_unit.sv -----
// A field's last byte is held in the input stage, then its value is registered in the result register.
// Throughput: one byte per cycle, sustained; the input stage holds a last byte
// only while the result register is still occupied and stalled.
// Reset (arst_n, asynchronous, active low): empties input stage and result
// register and returns the parser to expecting a field's first byte.
`default_nettype none
module tar_numeric_field_parser_unit
	import tfp_pkg::*;
#(
	parameter int VALUE_WIDTH = DefValueWidth
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tfp_byte_if.sink    byte_ch,
	tfp_value_if.source value_ch
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         last_s1;
	tfp_ctl_t                     ctl_q;
	logic signed [VALUE_WIDTH-1:0] acc_q;

	tfp_ctl_t                     ctl_nxt;
	logic signed [VALUE_WIDTH-1:0] acc_nxt;
	logic signed [OutWidth-1:0]   value;
	logic                         out_free;
	logic                         adv;

	// a last byte may only move on once the result slot is free
	assign adv = !last_s1 || out_free;
	assign byte_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
			last_s1 <= byte_ch.valid && byte_ch.field_last;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.field_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase <= PH_FIRST;
			ctl_q.neg <= 1'b0;
			acc_q <= '0;
		end else if (valid_s1 && adv) begin
			ctl_q <= ctl_nxt;
			acc_q <= acc_nxt;
		end
	end

	tfp_parse_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.ctl(ctl_q),
		.acc(acc_q),
		.field_byte(byte_s1),
		.field_last(last_s1),
		.ctl_nxt(ctl_nxt),
		.acc_nxt(acc_nxt),
		.value(value)
	);

	tfp_result_reg u_res (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1 && last_s1),
		.value(value),
		.free(out_free),
		.value_ch(value_ch)
	);

endmodule
`default_nettype wire

// ----- src/tfp_checker.sv -----
`default_nettype none
module tfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_value
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// a last byte taken while the sink stays ready gives a result after the input stage and result register
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last && out_ready) ##1 out_ready |=> out_valid)
		else $error("field end produced no result");

endmodule

bind tar_numeric_field_parser_unit tfp_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(byte_ch.valid),
	.in_ready(byte_ch.ready),
	.in_last(byte_ch.field_last),
	.out_valid(value_ch.valid),
	.out_ready(value_ch.ready),
	.out_value(value_ch.field_value)
);
`default_nettype wire

// ----- tb/tar_numeric_field_parser_unit_test.sv -----
`timescale 1ns / 100ps
module tar_numeric_field_parser_unit_test;
	import tfp_pkg::*;

	localparam longint ValMax = (longint'(1) <<< (DefValueWidth - 1)) - 1;
	localparam longint ValMin = -ValMax - 1;
	localparam int CycleLimit = 300000;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       hold;
	} byte_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tfp_byte_if  byte_ch ();
	tfp_value_if value_ch ();

	tar_numeric_field_parser_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.value_ch (value_ch)
	);

	initial forever #4 clk = ~clk;

	byte_req_t   pending_bytes[$];
	logic [7:0]  field_buf[$];
	logic [31:0] awaited_values[$];
	int          mismatches = 0;
	int          cycles = 0;
	logic        byte_taken = 1'b0;
	int          gap_left = 0;
	int          burst_left = 1;
	logic [15:0] stall_pat = 16'hffff;
	int          stall_pos = 0;

	// parser state as the block should hold it
	logic [2:0] ph = PH_FIRST;
	longint     acc = 0;
	logic       neg = 1'b0;

	function automatic void take_octal(logic [7:0] b);
		longint d;
		if (b < CH_ZERO || b > CH_SEVEN) begin
			ph = PH_STOPPED;
			return;
		end
		d = longint'(b - CH_ZERO);
		if (acc > ValMax / 8 || (acc == ValMax / 8 && d > ValMax % 8)) begin
			acc = ValMax;
			ph = PH_STOPPED;
			return;
		end
		acc = acc * 8 + d;
		ph = PH_DIGITS;
	endfunction

	function automatic bit parse_step(logic [7:0] b, logic last, output logic [31:0] value);
		longint v;
		value = '0;
		if (ph == PH_FIRST) begin
			if (b[7]) begin
				acc = longint'(b & 8'h3f);
				if (b[6])
					acc -= 64;
				ph = PH_B256;
			end else begin
				ph = PH_LEAD;
			end
		end else if (ph == PH_B256) begin
			// saturation is checked before the shift and then sticks
			if (acc > ValMax / 256) begin
				acc = ValMax;
				ph = PH_STOPPED;
			end else if (acc < ValMin / 256) begin
				acc = ValMin;
				ph = PH_STOPPED;
			end else begin
				acc = acc * 256 + longint'(b);
			end
		end
		if (ph == PH_LEAD) begin
			if (b == CH_SPACE || b == CH_TAB) begin
				// still skipping whitespace
			end else if (b == CH_MINUS && !neg) begin
				neg = 1'b1;
				ph = PH_DIGITS;
			end else begin
				take_octal(b);
			end
		end else if (ph == PH_DIGITS) begin
			take_octal(b);
		end
		if (!last)
			return 1'b0;
		v = neg ? -acc : acc;
		value = v[31:0];
		ph = PH_FIRST;
		acc = 0;
		neg = 1'b0;
		return 1'b1;
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			field_buf.push_back(s[i]);
	endtask

	task automatic commit_field(bit hold);
		byte_req_t r;
		for (int i = 0; i < field_buf.size(); i++) begin
			r.b = field_buf[i];
			r.last = (i == field_buf.size() - 1);
			r.hold = hold && (i == 0);
			pending_bytes.push_back(r);
		end
		field_buf.delete();
	endtask

	task automatic build_random_field(bit hold);
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			n = $urandom_range(0, 3);
			repeat (n)
				field_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			if ($urandom_range(0, 1))
				field_buf.push_back(CH_MINUS);
			// long digit runs reach the overflow region
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 8);
			repeat (n)
				field_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			case ($urandom_range(0, 3))
				0: field_buf.push_back(8'h00);
				1: field_buf.push_back(CH_SPACE);
				default: ;
			endcase
			n = $urandom_range(0, 2);
			repeat (n)
				field_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind <= 6) begin
			field_buf.push_back(8'h80 | 8'($urandom_range(0, 127)));
			n = $urandom_range(0, 5);
			repeat (n)
				field_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 8);
			repeat (n)
				field_buf.push_back(8'($urandom_range(0, 255)));
		end
		if (field_buf.size() == 0)
			field_buf.push_back(CH_SPACE);
		commit_field(hold);
	endtask

	// sender: bursts of requests separated by random gaps
	always @(negedge clk) begin : drive_bytes
		logic      nv;
		logic [7:0] nb;
		logic      nl;
		byte_req_t r;
		nv = byte_ch.valid;
		nb = byte_ch.field_byte;
		nl = byte_ch.field_last;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!byte_ch.valid || byte_taken) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_bytes.size() > 0 &&
				!(pending_bytes[0].hold && awaited_values.size() > 0)) begin
				r = pending_bytes.pop_front();
				nv = 1'b1;
				nb = r.b;
				nl = r.last;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		byte_ch.valid <= nv;
		byte_ch.field_byte <= nb;
		byte_ch.field_last <= nl;
	end

	// receiver: stalls follow a 16-bit pattern that is re-picked once it has been used up
	always @(negedge clk) begin : drive_ready
		if (stall_pos == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hffff;
				1: stall_pat = 16'($urandom());
				2: stall_pat = 16'($urandom()) & 16'($urandom()) | 16'h0001;
				default: stall_pat = 16'($urandom()) | 16'($urandom());
			endcase
		end
		value_ch.ready <= arst_n ? stall_pat[stall_pos] : 1'b0;
		stall_pos = (stall_pos + 1) % 16;
	end

	always @(posedge clk) begin : check_values
		logic [31:0] v;
		logic [31:0] want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= byte_ch.valid && byte_ch.ready;
			if (byte_ch.valid && byte_ch.ready) begin
				if (parse_step(byte_ch.field_byte, byte_ch.field_last, v))
					awaited_values.push_back(v);
			end
			if (value_ch.valid && value_ch.ready) begin
				if (awaited_values.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected value %0d (%h)", value_ch.field_value,
							value_ch.field_value);
				end else begin
					want = awaited_values.pop_front();
					if (value_ch.field_value !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("field_value mismatch: expected %0d (%h), got %0d (%h)",
								$signed(want), want, value_ch.field_value,
								value_ch.field_value);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("timeout with %0d values outstanding", awaited_values.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.field_byte = 8'h00;
		byte_ch.field_last = 1'b0;
		value_ch.ready = 1'b0;

		field_buf.push_back(8'h00);
		commit_field(0);
		field_buf.push_back(8'hff);
		commit_field(0);
		add_text(" \t-17");
		commit_field(0);
		// octal overflow with a minus gives the negated maximum
		add_text("-20000000000");
		commit_field(0);
		field_buf = {8'h80, 8'h7f, 8'h00, 8'h00, 8'h00};
		commit_field(0);
		field_buf = {8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
		commit_field(0);
		add_text("-");
		commit_field(0);

		build_random_field(1);
		for (int f = 1; pending_bytes.size() < 650; f++)
			build_random_field(f % 60 == 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_bytes.size() == 0 && !byte_ch.valid);
		wait (awaited_values.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_values.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
